>>> hdl/neighbor_pair_distance_screen_top_macros.svh
// Assertion macros used by the checker file.
// A clock named clk and an active-low reset named rst_n must be in scope.
`ifndef NEIGHBOR_PAIR_DISTANCE_SCREEN_TOP_MACROS_SVH
`define NEIGHBOR_PAIR_DISTANCE_SCREEN_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nps: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nps: next-cycle check failed");

`endif

>>> hdl/nps_pkg.sv
`default_nettype none

package nps_pkg;

    localparam int COORD_BITS_DEFAULT = 32;
    localparam int COUNT_BITS_DEFAULT = 16;

    localparam int COORD_W   = 32;
    localparam int ATOM_W    = 31;
    localparam int WORD_W    = 32;
    localparam int KEY_W     = 64;
    localparam int KEY_SHIFT = 32;
    localparam int SLOT_W    = 32;
    localparam int SURV_W    = 16;
    localparam int CUT_W     = 64;
    localparam int SUM_W     = 66;

    localparam logic [CUT_W-1:0] CUTOFF_RESET = 64'h0000_0004_0000_0000;

    // Slave-side tdata layout.
    localparam int HOME_ATOM_LSB = 0;
    localparam int HOME_X_LSB    = HOME_ATOM_LSB + ATOM_W;
    localparam int HOME_Y_LSB    = HOME_X_LSB + COORD_W;
    localparam int HOME_Z_LSB    = HOME_Y_LSB + COORD_W;
    localparam int PART_WORD_LSB = HOME_Z_LSB + COORD_W;
    localparam int PART_X_LSB    = PART_WORD_LSB + WORD_W;
    localparam int PART_Y_LSB    = PART_X_LSB + COORD_W;
    localparam int PART_Z_LSB    = PART_Y_LSB + COORD_W;
    localparam int S_DATA_W      = 256;
    localparam int S_USER_W      = 2;
    localparam int USER_HAS_PARTNER = 0;
    localparam int USER_FINAL_ATOM  = 1;

    // Master-side tdata is 176 bits, a whole number of bytes.
    localparam int M_DATA_W = KEY_W + SLOT_W + SURV_W + SLOT_W + SLOT_W;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic              kept;
        logic [ATOM_W-1:0] home_atom;
        logic [WORD_W-1:0] partner_word;
        logic              list_end;
        logic              final_atom;
    } nps_item_t;

endpackage

`default_nettype wire

>>> hdl/nps_front.sv
`default_nettype none

module nps_front #(
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [nps_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic [nps_pkg::S_USER_W-1:0]  s_tuser,
    input  wire logic                          cfg_wr_en,
    input  wire logic [nps_pkg::CUT_W-1:0]     cfg_wr_data,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output nps_pkg::nps_item_t                 push_item
);
    import nps_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int SQ_W = 2 * COORD_BITS;

    typedef struct packed {
        logic              has_partner;
        logic [ATOM_W-1:0] home_atom;
        logic [WORD_W-1:0] partner_word;
        logic              list_end;
        logic              final_atom;
    } meta_t;

    logic [CUT_W-1:0] cutoff_reg;
    logic             v0_reg, v1_reg, v2_reg;
    logic             r0, r1, r2;
    meta_t            meta_next, meta0_reg, meta1_reg, meta2_reg;

    logic [COORD_W-1:0]   home_c [3];
    logic [COORD_W-1:0]   part_c [3];
    logic signed [DW-1:0] diff_next [3];
    logic signed [DW-1:0] diff_reg [3];
    logic [PW-1:0]        prod [3];
    logic [SQ_W-1:0]      sq_reg [3];
    logic [SUM_W-1:0]     sum_wide;
    logic [CUT_W-1:0]     sum_next, sum_reg;

    assign home_c[0] = s_tdata[HOME_X_LSB +: COORD_W];
    assign home_c[1] = s_tdata[HOME_Y_LSB +: COORD_W];
    assign home_c[2] = s_tdata[HOME_Z_LSB +: COORD_W];
    assign part_c[0] = s_tdata[PART_X_LSB +: COORD_W];
    assign part_c[1] = s_tdata[PART_Y_LSB +: COORD_W];
    assign part_c[2] = s_tdata[PART_Z_LSB +: COORD_W];

    always_comb
    begin
        meta_next.has_partner  = s_tuser[USER_HAS_PARTNER];
        meta_next.home_atom    = s_tdata[HOME_ATOM_LSB +: ATOM_W];
        meta_next.partner_word = s_tdata[PART_WORD_LSB +: WORD_W];
        meta_next.list_end     = s_tlast;
        meta_next.final_atom   = s_tuser[USER_FINAL_ATOM];
        for (int a = 0; a < 3; a++)
        begin
            diff_next[a] = $signed({home_c[a][COORD_BITS-1], home_c[a][COORD_BITS-1:0]})
                         - $signed({part_c[a][COORD_BITS-1], part_c[a][COORD_BITS-1:0]});
            prod[a] = diff_reg[a] * diff_reg[a];
        end
        sum_wide = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        sum_next = (|sum_wide[SUM_W-1:CUT_W]) ? '1 : sum_wide[CUT_W-1:0];
    end

    assign r2       = !v2_reg || push_ready;
    assign r1       = !v1_reg || r2;
    assign r0       = !v0_reg || r1;
    assign s_tready = r0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RESET;
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cutoff_reg <= cfg_wr_data;
            end
            if (r0)
            begin
                v0_reg <= s_tvalid;
            end
            if (r1)
            begin
                v1_reg <= v0_reg;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r0)
        begin
            meta0_reg <= meta_next;
            for (int a = 0; a < 3; a++)
            begin
                diff_reg[a] <= diff_next[a];
            end
        end
        if (r1)
        begin
            meta1_reg <= meta0_reg;
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= prod[a][SQ_W-1:0];
            end
        end
        if (r2)
        begin
            meta2_reg <= meta1_reg;
            sum_reg   <= sum_next;
        end
    end

    always_comb
    begin
        push_valid             = v2_reg;
        push_item.kept         = meta2_reg.has_partner && (sum_reg < cutoff_reg);
        push_item.home_atom    = meta2_reg.home_atom;
        push_item.partner_word = meta2_reg.partner_word;
        push_item.list_end     = meta2_reg.list_end;
        push_item.final_atom   = meta2_reg.final_atom;
    end

endmodule

`default_nettype wire

>>> hdl/nps_queue.sv
`default_nettype none

module nps_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  nps_pkg::nps_item_t push_item,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output nps_pkg::nps_item_t pop_item
);
    import nps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    nps_item_t        slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/nps_back.sv
`default_nettype none

module nps_back #(
    parameter int COUNT_BITS = nps_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  nps_pkg::nps_item_t                 pop_item,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [nps_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import nps_pkg::*;

    logic [SLOT_W-1:0]     total_reg, total_next, total_new;
    logic [SLOT_W-1:0]     base_reg, base_next;
    logic [COUNT_BITS-1:0] count_reg, count_next, count_new;
    logic                  m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                  done, pop;
    logic [KEY_W-1:0]      key;

    assign pop_ready = !m_tvalid_reg || m_tready;
    assign pop       = pop_valid && pop_ready;
    assign done      = pop_item.list_end || pop_item.final_atom;
    assign key       = (KEY_W'(pop_item.home_atom) << KEY_SHIFT) | KEY_W'(pop_item.partner_word);

    always_comb
    begin
        total_new = pop_item.kept ? total_reg + SLOT_W'(1) : total_reg;
        count_new = count_reg;
        if (pop_item.kept && (count_reg != '1))
        begin
            count_new = count_reg + COUNT_BITS'(1);
        end
        total_next = total_new;
        base_next  = done ? total_new : base_reg;
        count_next = done ? '0 : count_new;
        if (pop_item.final_atom)
        begin
            total_next = '0;
            base_next  = '0;
            count_next = '0;
        end
        m_tdata_next = {total_new,
                        done ? base_reg : '0,
                        done ? SURV_W'(count_new) : '0,
                        pop_item.kept ? total_reg : '0,
                        pop_item.kept ? key : '0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            base_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                total_reg <= total_next;
                base_reg  <= base_next;
                count_reg <= count_next;
            end
            if (pop_ready)
            begin
                m_tvalid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= done;
            m_tuser_reg <= pop_item.kept;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

>>> hdl/neighbor_pair_distance_screen_top.sv
`default_nettype none

// Screens one candidate pair per item against the squared cutoff and numbers the survivors
// into one flat list, reporting each atom's survivor count and start offset at the end of
// its list. The block sustains one item per cycle with no gaps while m_tready does not
// stall the output; a result passes through the three-stage distance pipeline (differences,
// the three parallel coordinate multipliers, the saturating sum), the four-entry queue
// between the distance pipeline and the counting stage, and the output register. The cutoff
// register may be written only while no item is in flight.

module neighbor_pair_distance_screen_top #(
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEFAULT,
    parameter int COUNT_BITS = nps_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // home_atom, home_x, home_y, home_z, partner_word, partner_x, partner_y, partner_z, pad
    input  wire logic [nps_pkg::S_DATA_W-1:0]  s_tdata,
    // list_end
    input  wire logic                          s_tlast,
    // has_partner, final_atom
    input  wire logic [nps_pkg::S_USER_W-1:0]  s_tuser,
    input  wire logic                          cfg_wr_en,
    input  wire logic [nps_pkg::CUT_W-1:0]     cfg_wr_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pair_key, pair_slot, atom_survivors, atom_offset, total_pairs
    output logic [nps_pkg::M_DATA_W-1:0]       m_tdata,
    // atom_done
    output logic                               m_tlast,
    // kept
    output logic                               m_tuser
);
    import nps_pkg::*;

    logic      push_valid, push_ready, pop_valid, pop_ready;
    nps_item_t push_item, pop_item;

    nps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    nps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    nps_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> hdl/nps_checker.sv
`default_nettype none

`include "neighbor_pair_distance_screen_top_macros.svh"

module nps_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [nps_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tuser
);

    `NPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    `NPS_ASSERT_SAME(a_dropped_pair_zero, m_tvalid && !m_tuser, m_tdata[95:0] == 96'd0)

    `NPS_ASSERT_SAME(a_open_atom_zero, m_tvalid && !m_tlast, m_tdata[143:96] == 48'd0)

    `NPS_ASSERT_SAME(a_total_follows_slot, m_tvalid && m_tuser,
        m_tdata[175:144] == 32'(m_tdata[95:64] + 32'd1))

endmodule

bind neighbor_pair_distance_screen_top nps_checker u_nps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
);

`default_nettype wire
